FILE: sv/aes_cbc_pkg.sv
// Shared types, constants and byte-level AES functions for the CBC cipher engine.
package aes_cbc_pkg;

   localparam int RKW_DEFAULT = 60;

   typedef struct packed {
      logic        mode;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  byte_count;
      logic        first_block;
      logic        last_block;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  valid_bytes;
      logic        pad_error;
      logic        last_result;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CSR_KEY_LENGTH = 3'd0,
      CSR_KEY_PART_0 = 3'd1,
      CSR_KEY_PART_1 = 3'd2,
      CSR_KEY_PART_2 = 3'd3,
      CSR_KEY_PART_3 = 3'd4,
      CSR_IV_HIGH    = 3'd5,
      CSR_IV_LOW     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      KEY_128 = 2'd0,
      KEY_192 = 2'd1,
      KEY_256 = 2'd2
   } key_length_type;

   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [7:0] SBOX_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX_TABLE [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] rcon(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX_TABLE[w[31:24]], SBOX_TABLE[w[23:16]],
              SBOX_TABLE[w[15:8]], SBOX_TABLE[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i sits at bits 127-8i; row i%4, column i/4.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] m;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(c*4+r) -: 8] = SBOX_TABLE[get_byte(s, ((c + r) % 4)*4 + r)];
         end
      end
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, c*4);
         a1 = get_byte(t, c*4+1);
         a2 = get_byte(t, c*4+2);
         a3 = get_byte(t, c*4+3);
         m[127 - 8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[127 - 8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[127 - 8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return mix ? m : t;
   endfunction

   function automatic logic [7:0] mul9(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      return x8 ^ a;
   endfunction

   function automatic logic [7:0] mulb(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      return x8 ^ x2 ^ a;
   endfunction

   function automatic logic [7:0] muld(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      return x8 ^ x4 ^ a;
   endfunction

   function automatic logic [7:0] mule(input logic [7:0] a);
      logic [7:0] x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      return x8 ^ x4 ^ x2;
   endfunction

   // Inverse shift and substitution, key add, then inverse mix when asked.
   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic mix);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] m;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(c*4+r) -: 8] = INV_SBOX_TABLE[get_byte(s, ((c + 4 - r) % 4)*4 + r)];
         end
      end
      t = t ^ k;
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(t, c*4);
         a1 = get_byte(t, c*4+1);
         a2 = get_byte(t, c*4+2);
         a3 = get_byte(t, c*4+3);
         m[127 - 8*(c*4)   -: 8] = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
         m[127 - 8*(c*4+1) -: 8] = mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3);
         m[127 - 8*(c*4+2) -: 8] = muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3);
         m[127 - 8*(c*4+3) -: 8] = mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3);
      end
      return mix ? m : t;
   endfunction

endpackage

FILE: sv/aes_cbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aes_cbc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/aes_cbc_cipher_engine.sv
// AES-128/192/256 CBC engine with PKCS7 padding, one round per cycle on a shared round unit.
//
//   channel   ports                                     direction
//   request   req_valid, req_stall, req_payload         in
//   response  rsp_valid, rsp_stall, rsp_payload         out
//   csr       csr_write_enable, csr_index, csr_write_data  in
//
// A block goes through accept, one round key fetch, nr+1 passes through the round
// unit (nr is 10, 12 or 14 rounds), and the result write.
// A full final encrypt block is followed by a padding block, which goes back through the fetch.
// After reset and after each key or key length write, key expansion computes one word
// a cycle and writes the round key store a row at a time; requests stall meanwhile.
// A response waiting on rsp_stall holds the sequencer in its result cycle.
module aes_cbc_cipher_engine
   import aes_cbc_pkg::*;
#(
   parameter int ROUND_KEY_WORDS = RKW_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_index,
   input  logic [63:0]     csr_write_data
);

   localparam int ROW_COUNT = (ROUND_KEY_WORDS + 3) / 4;
   localparam int ROW_AW    = $clog2(ROW_COUNT);
   localparam logic [5:0] RKW_LIMIT = 6'(ROUND_KEY_WORDS);
   localparam logic [3:0] ROW_LIMIT = 4'(ROW_COUNT);

   typedef enum logic [4:0] {
      ST_KEYEXP = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_ROUND  = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [1:0]      key_len_ff, key_len_in;
   logic [63:0]     key_part_ff [4];
   logic [63:0]     key_part_in [4];
   logic [63:0]     iv_high_ff, iv_high_in, iv_low_ff, iv_low_in;

   logic [5:0]      exp_idx_ff, exp_idx_in;
   logic [2:0]      exp_mod_ff, exp_mod_in;
   logic [3:0]      exp_quo_ff, exp_quo_in;
   logic [31:0]     win_ff [8];
   logic [31:0]     win_in [8];

   logic [3:0]      step_ff, step_in;
   logic [127:0]    blk_ff, blk_in;
   logic [127:0]    saved_ff, saved_in;
   logic [127:0]    chain_ff, chain_in;
   logic            decrypt_ff, decrypt_in;
   logic            last_ff, last_in;
   logic            extra_ff, extra_in;
   logic            oor_ff, oor_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [3:0]      nr, nk;
   logic [5:0]      exp_total;
   logic [31:0]     exp_word, exp_temp;
   logic            ram_we;
   logic [ROW_AW-1:0] ram_waddr, ram_raddr;
   logic [127:0]    ram_wdata, ram_rdata, round_key;
   logic [3:0]      rd_row;
   logic            key_write;

   aes_cbc_ram #(.WIDTH(128), .DEPTH(ROW_COUNT)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      unique case (key_len_ff)
         KEY_128: nr = 4'd10;
         KEY_192: nr = 4'd12;
         default: nr = 4'd14;
      endcase
      nk        = nr - 4'd6;
      exp_total = {nr, 2'b00} + 6'd4;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign key_write   = csr_write_enable && (csr_index <= CSR_KEY_PART_3);
   assign round_key   = oor_ff ? 128'd0 : ram_rdata;

   // Key expansion word for index exp_idx_ff.
   always_comb begin
      logic [63:0] part;
      part     = key_part_ff[exp_idx_ff[2:1]];
      exp_temp = win_ff[0];
      if (exp_mod_ff == 3'd0) begin
         exp_temp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon(exp_quo_ff), 24'd0};
      end else if (nk == 4'd8 && exp_mod_ff == 3'd4) begin
         exp_temp = sub_word(win_ff[0]);
      end
      if (exp_idx_ff < {2'b00, nk}) begin
         exp_word = exp_idx_ff[0] ? part[31:0] : part[63:32];
      end else begin
         exp_word = win_ff[nk[2:0] - 3'd1] ^ exp_temp;
      end
   end

   // Row write after the fourth word; words past the store's end are zero.
   always_comb begin
      logic [31:0] words [4];
      words[0] = win_ff[2];
      words[1] = win_ff[1];
      words[2] = win_ff[0];
      words[3] = exp_word;
      for (int k = 0; k < 4; k++) begin
         if ({exp_idx_ff[5:2], 2'(k)} >= RKW_LIMIT) begin
            words[k] = 32'd0;
         end
      end
      ram_wdata = {words[0], words[1], words[2], words[3]};
      ram_waddr = exp_idx_ff[2 +: ROW_AW];
      ram_we    = (state_ff == ST_KEYEXP) && (exp_idx_ff[1:0] == 2'd3)
                  && (exp_idx_ff[5:2] < ROW_LIMIT);
   end

   // Next round key row: encrypt counts up from zero, decrypt counts down from nr.
   always_comb begin
      if (state_ff == ST_ROUND) begin
         rd_row = decrypt_ff ? (nr - step_ff - 4'd1) : (step_ff + 4'd1);
      end else begin
         rd_row = decrypt_ff ? nr : 4'd0;
      end
      oor_in    = (rd_row >= ROW_LIMIT);
      ram_raddr = rd_row[ROW_AW-1:0];
   end

   always_comb begin
      logic [4:0]   cnt;
      logic [7:0]   pad;
      logic [127:0] chain_sel;
      logic [127:0] fin;
      logic [7:0]   p;
      logic         ok;

      state_in     = state_ff;
      key_len_in   = key_len_ff;
      key_part_in  = key_part_ff;
      iv_high_in   = iv_high_ff;
      iv_low_in    = iv_low_ff;
      exp_idx_in   = exp_idx_ff;
      exp_mod_in   = exp_mod_ff;
      exp_quo_in   = exp_quo_ff;
      win_in       = win_ff;
      step_in      = step_ff;
      blk_in       = blk_ff;
      saved_in     = saved_ff;
      chain_in     = chain_ff;
      decrypt_in   = decrypt_ff;
      last_in      = last_ff;
      extra_in     = extra_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cnt       = (req_payload.byte_count > 5'd16) ? 5'd16 : req_payload.byte_count;
      pad       = 8'(5'd16 - cnt);
      chain_sel = req_payload.first_block ? {iv_high_ff, iv_low_ff} : chain_ff;
      fin       = decrypt_ff ? (blk_ff ^ chain_ff) : blk_ff;
      p         = fin[7:0];
      ok        = (p >= 8'd1) && (p <= 8'd16);
      for (int j = 0; j < 16; j++) begin
         if ((8'(15 - j) < p) && (get_byte(fin, j) != p)) begin
            ok = 1'b0;
         end
      end

      unique case (state_ff)
         ST_KEYEXP: begin
            for (int k = 7; k > 0; k--) begin
               win_in[k] = win_ff[k-1];
            end
            win_in[0]  = exp_word;
            exp_idx_in = exp_idx_ff + 6'd1;
            if (exp_mod_ff == nk[2:0] - 3'd1) begin
               exp_mod_in = 3'd0;
               exp_quo_in = exp_quo_ff + 4'd1;
            end else begin
               exp_mod_in = exp_mod_ff + 3'd1;
            end
            if (exp_idx_ff == exp_total - 6'd1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               decrypt_in = (req_payload.mode == MODE_DECRYPT);
               last_in    = req_payload.last_block;
               chain_in   = chain_sel;
               saved_in   = {req_payload.data_high, req_payload.data_low};
               extra_in   = (req_payload.mode != MODE_DECRYPT) && req_payload.last_block
                            && (cnt == 5'd16);
               if (req_payload.mode == MODE_DECRYPT) begin
                  blk_in = {req_payload.data_high, req_payload.data_low};
               end else begin
                  for (int j = 0; j < 16; j++) begin
                     blk_in[127 - 8*j -: 8] =
                        (req_payload.last_block && (5'(j) >= cnt)) ? pad
                        : get_byte({req_payload.data_high, req_payload.data_low}, j);
                  end
                  blk_in = blk_in ^ chain_sel;
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            step_in  = 4'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (step_ff == 4'd0) begin
               blk_in = blk_ff ^ round_key;
            end else if (decrypt_ff) begin
               blk_in = dec_round(blk_ff, round_key, step_ff != nr);
            end else begin
               blk_in = enc_round(blk_ff, step_ff != nr) ^ round_key;
            end
            step_in = step_ff + 4'd1;
            if (step_ff == nr) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_high    = fin[127:64];
               rsp_in.out_low     = fin[63:0];
               rsp_in.valid_bytes = 5'd16;
               rsp_in.pad_error   = 1'b0;
               rsp_in.last_result = !extra_ff;
               if (decrypt_ff && last_ff) begin
                  rsp_in.valid_bytes = ok ? 5'(8'd16 - p) : 5'd0;
                  rsp_in.pad_error   = !ok;
               end
               chain_in = decrypt_ff ? saved_ff : blk_ff;
               if (extra_ff) begin
                  // follow with a block made only of padding
                  blk_in   = {16{8'h10}} ^ blk_ff;
                  extra_in = 1'b0;
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LENGTH: key_len_in     = csr_write_data[1:0];
            CSR_KEY_PART_0: key_part_in[0] = csr_write_data;
            CSR_KEY_PART_1: key_part_in[1] = csr_write_data;
            CSR_KEY_PART_2: key_part_in[2] = csr_write_data;
            CSR_KEY_PART_3: key_part_in[3] = csr_write_data;
            CSR_IV_HIGH:    iv_high_in     = csr_write_data;
            CSR_IV_LOW:     iv_low_in      = csr_write_data;
            default:        ;
         endcase
      end
      // restart expansion on any key change
      if (key_write) begin
         state_in   = ST_KEYEXP;
         exp_idx_in = 6'd0;
         exp_mod_in = 3'd0;
         exp_quo_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEYEXP;
         key_len_ff   <= KEY_128;
         for (int k = 0; k < 4; k++) begin
            key_part_ff[k] <= 64'd0;
         end
         iv_high_ff   <= 64'd0;
         iv_low_ff    <= 64'd0;
         chain_ff     <= 128'd0;
         exp_idx_ff   <= 6'd0;
         exp_mod_ff   <= 3'd0;
         exp_quo_ff   <= 4'd0;
         rsp_valid_ff <= 1'b0;
         extra_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_len_ff   <= key_len_in;
         key_part_ff  <= key_part_in;
         iv_high_ff   <= iv_high_in;
         iv_low_ff    <= iv_low_in;
         chain_ff     <= chain_in;
         exp_idx_ff   <= exp_idx_in;
         exp_mod_ff   <= exp_mod_in;
         exp_quo_ff   <= exp_quo_in;
         rsp_valid_ff <= rsp_valid_in;
         extra_ff     <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff     <= win_in;
      step_ff    <= step_in;
      blk_ff     <= blk_in;
      saved_ff   <= saved_in;
      decrypt_ff <= decrypt_in;
      last_ff    <= last_in;
      oor_ff     <= oor_in;
      rsp_ff     <= rsp_in;
   end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the AES CBC cipher engine with PKCS7 padding.
`timescale 1ns / 100ps

module tb
   import aes_cbc_pkg::*;
();

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable;
   logic [2:0]      csr_index;
   logic [63:0]     csr_write_data;

   aes_cbc_cipher_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Cipher state mirrored from the CSR writes and accepted requests.
   logic [7:0]   fwd_sub [256];
   logic [7:0]   inv_sub [256];
   logic [31:0]  sched [60];
   logic [1:0]   klen;
   logic [63:0]  key_word [4];
   logic [127:0] iv_value;
   logic [127:0] chain;

   rsp_payload_type cipher_q [$];
   int err_count;
   int n_requests, n_blocks, n_pad_errors, n_good_unpad, n_extra_pad;
   logic quiet;
   logic long_hold_req;
   int   rsp_wait, long_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("timeout: %0d results still outstanding", cipher_q.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // Build the S-box from the field inverse and the affine map.
   task automatic build_sbox();
      logic [7:0] inv, s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_sub[x] = s;
         inv_sub[s] = x[7:0];
      end
   endtask

   function automatic int round_count();
      return klen == KEY_128 ? 10 : (klen == KEY_192 ? 12 : 14);
   endfunction

   task automatic expand_key();
      int nk, total;
      logic [31:0] t;
      logic [7:0]  rc;
      nk = round_count() - 6;
      total = 4 * (round_count() + 1);
      for (int i = 0; i < 60; i++) sched[i] = 32'h0;
      for (int i = 0; i < nk; i++)
         sched[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
      for (int i = nk; i < total; i++) begin
         t = sched[i-1];
         if (i % nk == 0) begin
            rc = 8'h01;
            for (int j = 1; j < i / nk; j++) rc = gf_mul(rc, 8'h02);
            t = {t[23:0], t[31:24]};
            t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]}
                ^ {rc, 24'h0};
         end else if (nk > 6 && i % nk == 4) begin
            t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
         end
         sched[i] = sched[i-nk] ^ t;
      end
   endtask

   function automatic logic [127:0] mix_key(input logic [127:0] s, input int rnd);
      return s ^ {sched[rnd*4], sched[rnd*4+1], sched[rnd*4+2], sched[rnd*4+3]};
   endfunction

   function automatic logic [127:0] cipher_fwd(input logic [127:0] s);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      int nr;
      nr = round_count();
      s = mix_key(s, 0);
      for (int r = 1; r <= nr; r++) begin
         for (int i = 0; i < 16; i++) b[i] = fwd_sub[s[127-8*i -: 8]];
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[c*4+w] = b[((c + w) & 3)*4 + w];
         if (r != nr)
            for (int c = 0; c < 4; c++) begin
               a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
               t[c*4]   = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
               t[c*4+1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
               t[c*4+2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
               t[c*4+3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
            end
         for (int i = 0; i < 16; i++) s[127-8*i -: 8] = t[i];
         s = mix_key(s, r);
      end
      return s;
   endfunction

   function automatic logic [127:0] cipher_inv(input logic [127:0] s);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      int nr;
      nr = round_count();
      s = mix_key(s, nr);
      for (int r = nr - 1; r >= 0; r--) begin
         for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[c*4+w] = inv_sub[b[((c + 4 - w) & 3)*4 + w]];
         for (int i = 0; i < 16; i++) s[127-8*i -: 8] = t[i];
         s = mix_key(s, r);
         if (r != 0) begin
            for (int i = 0; i < 16; i++) t[i] = s[127-8*i -: 8];
            for (int c = 0; c < 4; c++) begin
               a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
               t[c*4]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                          ^ gf_mul(a3, 8'd9);
               t[c*4+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                          ^ gf_mul(a3, 8'd13);
               t[c*4+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                          ^ gf_mul(a3, 8'd11);
               t[c*4+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                          ^ gf_mul(a3, 8'd14);
            end
            for (int i = 0; i < 16; i++) s[127-8*i -: 8] = t[i];
         end
      end
      return s;
   endfunction

   // Push the results an accepted request must produce and advance the chain.
   task automatic predict_blocks(input req_payload_type p);
      rsp_payload_type r;
      logic [127:0] blk, ct;
      logic [7:0]   pv;
      int cnt;
      logic ok;
      n_requests++;
      if (p.first_block) chain = iv_value;
      blk = {p.data_high, p.data_low};
      r.pad_error = 1'b0;
      r.valid_bytes = 5'd16;
      r.last_result = 1'b1;
      if (p.mode == MODE_DECRYPT) begin
         ct = blk;
         blk = cipher_inv(blk) ^ chain;
         chain = ct;
         if (p.last_block) begin
            pv = blk[7:0];
            ok = pv >= 1 && pv <= 16;
            for (int i = 0; i < 16; i++)
               if (ok && i < pv && blk[8*i +: 8] != pv) ok = 1'b0;
            r.valid_bytes = ok ? 5'(16 - pv) : 5'd0;
            r.pad_error = !ok;
            if (ok) n_good_unpad++; else n_pad_errors++;
         end
         {r.out_high, r.out_low} = blk;
         cipher_q.push_back(r);
         return;
      end
      cnt = p.byte_count > 16 ? 16 : p.byte_count;
      if (p.last_block && cnt < 16)
         for (int i = cnt; i < 16; i++) blk[127-8*i -: 8] = 8'(16 - cnt);
      chain = cipher_fwd(blk ^ chain);
      {r.out_high, r.out_low} = chain;
      if (p.last_block && cnt == 16) begin
         r.last_result = 1'b0;
         cipher_q.push_back(r);
         chain = cipher_fwd({16{8'h10}} ^ chain);
         {r.out_high, r.out_low} = chain;
         r.last_result = 1'b1;
         n_extra_pad++;
      end
      cipher_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [127:0] got,
                                  input logic [127:0] want);
      err_count++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
   endtask

   // Response side: draw a stall per result, plus one long hold on request.
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_blocks++;
         if (cipher_q.size() == 0) begin
            report_mismatch("unexpected result", {rsp_payload.out_high, rsp_payload.out_low},
                            128'd0);
         end else begin
            e = cipher_q.pop_front();
            if ({rsp_payload.out_high, rsp_payload.out_low} != {e.out_high, e.out_low})
               report_mismatch("block", {rsp_payload.out_high, rsp_payload.out_low},
                               {e.out_high, e.out_low});
            if (rsp_payload.valid_bytes != e.valid_bytes)
               report_mismatch("valid_bytes", 128'(rsp_payload.valid_bytes),
                               128'(e.valid_bytes));
            if (rsp_payload.pad_error != e.pad_error)
               report_mismatch("pad_error", 128'(rsp_payload.pad_error), 128'(e.pad_error));
            if (rsp_payload.last_result != e.last_result)
               report_mismatch("last_result", 128'(rsp_payload.last_result),
                               128'(e.last_result));
         end
         rsp_wait <= quiet ? 0 : $urandom_range(0, 8);
      end
   end

   always @(negedge clock) begin
      if (long_hold_req && long_hold == 0) begin
         long_hold = 400;
         long_hold_req = 1'b0;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_KEY_LENGTH: klen = value[1:0];
         CSR_KEY_PART_0: key_word[0] = value;
         CSR_KEY_PART_1: key_word[1] = value;
         CSR_KEY_PART_2: key_word[2] = value;
         CSR_KEY_PART_3: key_word[3] = value;
         CSR_IV_HIGH:    iv_value[127:64] = value;
         CSR_IV_LOW:     iv_value[63:0] = value;
         default: ;
      endcase
      if (idx != CSR_IV_HIGH && idx != CSR_IV_LOW) expand_key();
   endtask

   task automatic send_request(input req_payload_type p);
      int gap;
      req_payload = p;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_blocks(p);
      gap = quiet ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Ciphertext that decrypts to the given plaintext at the current chain position.
   function automatic logic [127:0] forge_cipher(input logic [127:0] plain, input logic first);
      return cipher_fwd(plain ^ (first ? iv_value : chain));
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [127:0] padded_plain(input int pv);
      logic [127:0] b;
      b = {rand64(), rand64()};
      for (int i = 0; i < pv; i++) b[8*i +: 8] = 8'(pv);
      return b;
   endfunction

   task automatic send_message();
      req_payload_type p;
      int n, pv;
      logic dec;
      n = $urandom_range(1, 5);
      dec = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
         p.mode = ($urandom_range(0, 19) == 0) ? ~dec : dec;
         p.first_block = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
         p.last_block = (k == n - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
         p.data_high = rand64();
         p.data_low = rand64();
         case ($urandom_range(0, 5))
            0:       p.byte_count = 5'($urandom_range(17, 31));
            1, 2:    p.byte_count = 5'd16;
            default: p.byte_count = 5'($urandom_range(0, 15));
         endcase
         if (p.mode == MODE_DECRYPT && $urandom_range(0, 9) < 8) begin
            pv = p.last_block ? $urandom_range(1, 16) : 0;
            {p.data_high, p.data_low} = forge_cipher(padded_plain(pv), p.first_block);
         end
         send_request(p);
      end
   endtask

   // Drop the request line, then drain every outstanding result.
   task automatic settle();
      req_valid = 1'b0;
      while (cipher_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   typedef struct {
      req_payload_type req;
      int              forge_pad;
      logic            typed;
      logic [127:0]    want_block;
      logic [4:0]      want_valid;
      logic            want_err;
   } vector_row_type;

   vector_row_type vectors [] = '{
      // zero key, zero chain, zero plaintext: the standard all-zero ciphertext
      '{'{1'b0, 64'h0, 64'h0, 5'd16, 1'b0, 1'b0}, 0, 1'b1,
        128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 5'd16, 1'b0},
      // decrypt it back from the zero IV: all-zero plaintext is bad padding
      '{'{1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 5'd16, 1'b1, 1'b1}, 0, 1'b1,
        128'h0, 5'd0, 1'b1},
      '{'{1'b0, '1, '1, 5'd0, 1'b1, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '1, '1, 5'd15, 1'b1, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, 64'h0123456789abcdef, '1, 5'd16, 1'b1, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '0, '1, 5'd31, 1'b0, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '1, '0, 5'd17, 1'b1, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '1, '0, 5'd3, 1'b1, 1'b0}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '0, '0, 5'd31, 1'b0, 1'b0}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, '1, '1, 5'd16, 1'b0, 1'b0}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, '0, '0, 5'd16, 1'b1, 1'b1}, 16, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, '0, '0, 5'd16, 1'b1, 1'b1}, 1, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, '0, '0, 5'd0, 1'b0, 1'b1}, 7, 1'b0, 128'h0, 5'd0, 1'b0},
      // mixed direction within one chain
      '{'{1'b0, 64'hfedcba9876543210, '0, 5'd16, 1'b1, 1'b0}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, 64'h5555aaaa5555aaaa, '1, 5'd16, 1'b0, 1'b0}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b0, '1, '1, 5'd9, 1'b0, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0},
      '{'{1'b1, '1, '1, 5'd0, 1'b1, 1'b1}, 0, 1'b0, 128'h0, 5'd0, 1'b0}
   };

   initial begin
      req_payload_type p;
      rsp_payload_type want;
      err_count = 0;
      n_requests = 0; n_blocks = 0; n_pad_errors = 0; n_good_unpad = 0; n_extra_pad = 0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      long_hold = 0;
      rsp_wait = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_KEY_LENGTH;
      csr_write_data = '0;
      build_sbox();
      klen = KEY_128;
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      iv_value = '0;
      chain = '0;
      expand_key();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (vectors[i]) begin
         p = vectors[i].req;
         if (vectors[i].forge_pad != 0)
            {p.data_high, p.data_low} =
               forge_cipher(padded_plain(vectors[i].forge_pad), p.first_block);
         send_request(p);
         if (vectors[i].typed) begin
            // the newest prediction cannot have drained yet: the block is still in the round passes
            want = cipher_q[$];
            if ({want.out_high, want.out_low} != vectors[i].want_block ||
                want.valid_bytes != vectors[i].want_valid || want.pad_error != vectors[i].want_err)
               report_mismatch("known vector", {want.out_high, want.out_low},
                               vectors[i].want_block);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: write_csr(CSR_KEY_LENGTH, 64'd2);
            1: write_csr(CSR_KEY_LENGTH, 64'd1);
            2: write_csr(CSR_KEY_LENGTH, {62'h0, 2'd3});
            3: write_csr(CSR_KEY_LENGTH, '1);
            default: write_csr(CSR_KEY_LENGTH, {$urandom, $urandom});
         endcase
         write_csr(CSR_KEY_PART_0, ph == 0 ? '1 : (ph == 1 ? '0 : rand64()));
         write_csr(CSR_KEY_PART_1, ph == 0 ? '1 : (ph == 1 ? '0 : rand64()));
         write_csr(CSR_KEY_PART_2, ph == 0 ? '1 : (ph == 1 ? '0 : rand64()));
         write_csr(CSR_KEY_PART_3, ph == 0 ? '1 : (ph == 1 ? '0 : rand64()));
         write_csr(CSR_IV_HIGH, ph == 1 ? '1 : rand64());
         write_csr(CSR_IV_LOW, ph == 1 ? '1 : rand64());
         quiet = (ph == 5);
         // fill the engine: hold results while requests keep coming
         if (ph == 3) long_hold_req = 1'b1;
         while (n_requests < 25 + (ph + 1) * 190) send_message();
      end
      settle();
      if (cipher_q.size() != 0) begin
         err_count += cipher_q.size();
         $display("%0d expected results never arrived", cipher_q.size());
      end
      $display("covered %0d requests and %0d result blocks over 8 key settings", n_requests,
               n_blocks);
      $display("final blocks: %0d unpadded, %0d padding errors, %0d extra padding blocks",
               n_good_unpad, n_pad_errors, n_extra_pad);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", err_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/aes_cbc_pkg.sv
sv/aes_cbc_ram.sv
sv/aes_cbc_cipher_engine.sv
tb/tb.sv
